FILE: hdl/mme_pkg.sv
// Shared types and codes for the matrix multiply-accumulate engine.
package mme_pkg;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MAC  = 5'b00010,
      ST_EMIT = 5'b00100,
      ST_COPY = 5'b01000,
      ST_HOLD = 5'b10000
   } state_type;

   localparam logic [1:0] CMD_WRITE_A = 2'd0;
   localparam logic [1:0] CMD_WRITE_B = 2'd1;
   localparam logic [1:0] CMD_START   = 2'd2;

   localparam logic [2:0] OP_AB    = 3'd0;
   localparam logic [2:0] OP_ATB   = 3'd1;
   localparam logic [2:0] OP_ABT   = 3'd2;
   localparam logic [2:0] OP_ADD   = 3'd3;
   localparam logic [2:0] OP_SUB   = 3'd4;
   localparam logic [2:0] OP_SADD  = 3'd5;
   localparam logic [2:0] OP_SMUL  = 3'd6;

   localparam logic [2:0] REG_OP_MODE = 3'd0;
   localparam logic [2:0] REG_A_ROWS  = 3'd1;
   localparam logic [2:0] REG_A_COLS  = 3'd2;
   localparam logic [2:0] REG_B_ROWS  = 3'd3;
   localparam logic [2:0] REG_B_COLS  = 3'd4;
   localparam logic [2:0] REG_SCALAR  = 3'd5;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_SHAPE = 1'b1;

   // 8 exact 64-bit products need 3 guard bits
   localparam int ACC_W = 67;

endpackage

FILE: hdl/mme_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mme_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: hdl/matrix_mac_engine_core.sv
// Matrix multiply-accumulate engine: element stores, one shared MAC, result write-back.
// Loads: each beat writes A or B while idle. Start: each result element is built from n
// reads and products through the registered-read RAM port and one shared 32x32 MAC; the
// MAC pipe drains, the element is emitted, and at the end the result is copied over A.
// The next beat is taken after the copy. Shape error: one beat, no copy. Reset (sync,
// active high) clears control and registers; element stores are undefined until written.
module matrix_mac_engine_core #(
   parameter int MAX_DIM   = 8,
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [2:0]         req_elem_row,
   input  logic [2:0]         req_elem_col,
   input  logic signed [31:0] req_elem_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_out_row,
   output logic [2:0]         rsp_out_col,
   output logic signed [31:0] rsp_out_value,
   output logic               rsp_last_flag,
   output logic               rsp_status,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wr_data
);
   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ACC_W = mme_pkg::ACC_W;

   function automatic logic [AW-1:0] cell_addr(input logic [3:0] r, input logic [3:0] c);
      cell_addr = AW'(int'(r) * MAX_DIM + int'(c));
   endfunction

   function automatic logic [3:0] eff_count(input logic [3:0] c);
      if (c == 4'd0) eff_count = 4'd1;
      else if (c > 4'(MAX_DIM)) eff_count = 4'(MAX_DIM);
      else eff_count = c;
   endfunction

   mme_pkg::state_type state_ff, state_in;
   logic [2:0]  op_mode_ff, op_mode_in;
   logic [3:0]  a_rows_ff, a_rows_in, a_cols_ff, a_cols_in;
   logic [3:0]  b_rows_ff, b_rows_in, b_cols_ff, b_cols_in;
   logic signed [31:0] scalar_ff, scalar_in;

   logic [2:0]  mode_ff, mode_in;
   logic [3:0]  rr_ff, rr_in, rc_ff, rc_in, n_ff, n_in;
   logic [3:0]  i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic        v1_ff, v1_in, v2_ff, v2_in;
   logic signed [63:0]      prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [31:0]      a_d_ff, a_d_in, b_d_ff, b_d_in;
   logic [3:0]  cr_ff, cr_in, cc_ff, cc_in;
   logic        cp_v_ff, cp_v_in;
   logic [AW-1:0] cp_addr_ff, cp_addr_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic signed [31:0] rsp_value_ff, rsp_value_in;
   logic        rsp_last_ff, rsp_last_in, rsp_status_ff, rsp_status_in;

   logic          a_we, b_we, r_we;
   logic [AW-1:0] a_waddr, b_waddr, r_waddr, a_raddr, b_raddr, r_raddr;
   logic [31:0]   a_wdata, r_wdata, a_rdata, b_rdata, r_rdata;

   logic req_acc, room, issue, last_elem, in_range;
   logic [3:0] ear, eac, ebr, ebc;
   logic signed [ACC_W-1:0] acc_sh;
   logic signed [32:0] sum33;
   logic signed [31:0] result;
   logic signed [31:0] mul_b;

   mme_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_a (
      .clock(clock), .wr_en(a_we), .wr_addr(a_waddr), .wr_data(a_wdata),
      .rd_addr(a_raddr), .rd_data(a_rdata));
   mme_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_b (
      .clock(clock), .wr_en(b_we), .wr_addr(b_waddr), .wr_data(req_elem_value),
      .rd_addr(b_raddr), .rd_data(b_rdata));
   mme_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_r (
      .clock(clock), .wr_en(r_we), .wr_addr(r_waddr), .wr_data(r_wdata),
      .rd_addr(r_raddr), .rd_data(r_rdata));

   assign req_stall = (state_ff != mme_pkg::ST_IDLE) || rsp_valid_ff;
   assign req_acc   = req_valid && !req_stall;
   assign room      = !rsp_valid_ff || !rsp_stall;
   assign last_elem = (i_ff == rr_ff - 4'd1) && (j_ff == rc_ff - 4'd1);
   assign in_range  = ({1'b0, req_elem_row} < 4'(MAX_DIM)) &&
                      ({1'b0, req_elem_col} < 4'(MAX_DIM));
   assign ear = eff_count(a_rows_ff);
   assign eac = eff_count(a_cols_ff);
   assign ebr = eff_count(b_rows_ff);
   assign ebc = eff_count(b_cols_ff);
   assign mul_b = (mode_ff == mme_pkg::OP_SMUL) ? scalar_ff : $signed(b_rdata);

   // result of the current element
   always_comb begin
      acc_sh = acc_ff >>> FRAC_BITS;
      sum33  = 33'sd0;
      case (mode_ff)
         mme_pkg::OP_ADD:  sum33 = {a_d_ff[31], a_d_ff} + {b_d_ff[31], b_d_ff};
         mme_pkg::OP_SUB:  sum33 = {a_d_ff[31], a_d_ff} - {b_d_ff[31], b_d_ff};
         mme_pkg::OP_SADD: sum33 = {a_d_ff[31], a_d_ff} + {b_d_ff[31], b_d_ff};
         default:          sum33 = 33'sd0;
      endcase
      if (mode_ff inside {mme_pkg::OP_ADD, mme_pkg::OP_SUB, mme_pkg::OP_SADD}) begin
         if (sum33[32] != sum33[31]) result = sum33[32] ? 32'sh80000000 : 32'sh7fffffff;
         else result = sum33[31:0];
      end else begin
         if (!((&acc_sh[ACC_W-1:31]) || !(|acc_sh[ACC_W-1:31])))
            result = acc_sh[ACC_W-1] ? 32'sh80000000 : 32'sh7fffffff;
         else result = acc_sh[31:0];
      end
   end

   always_comb begin
      state_in   = state_ff;
      op_mode_in = op_mode_ff;
      a_rows_in  = a_rows_ff;
      a_cols_in  = a_cols_ff;
      b_rows_in  = b_rows_ff;
      b_cols_in  = b_cols_ff;
      scalar_in  = scalar_ff;
      mode_in = mode_ff; rr_in = rr_ff; rc_in = rc_ff; n_in = n_ff;
      i_in = i_ff; j_in = j_ff; k_in = k_ff;
      v1_in = 1'b0; v2_in = 1'b0;
      prod_in = prod_ff; acc_in = acc_ff; a_d_in = a_d_ff; b_d_in = b_d_ff;
      cr_in = cr_ff; cc_in = cc_ff; cp_v_in = 1'b0; cp_addr_in = cp_addr_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      issue = 1'b0;
      a_we = 1'b0; b_we = 1'b0; r_we = 1'b0;
      a_waddr = cell_addr({1'b0, req_elem_row}, {1'b0, req_elem_col});
      b_waddr = a_waddr;
      a_wdata = req_elem_value;
      r_waddr = cell_addr(i_ff, j_ff);
      r_wdata = result;
      r_raddr = cell_addr(cr_ff, cc_ff);
      case (mode_ff)
         mme_pkg::OP_AB:  begin a_raddr = cell_addr(i_ff, k_ff); b_raddr = cell_addr(k_ff, j_ff); end
         mme_pkg::OP_ATB: begin a_raddr = cell_addr(k_ff, i_ff); b_raddr = cell_addr(k_ff, j_ff); end
         mme_pkg::OP_ABT: begin a_raddr = cell_addr(i_ff, k_ff); b_raddr = cell_addr(j_ff, k_ff); end
         default:         begin a_raddr = cell_addr(i_ff, j_ff); b_raddr = cell_addr(i_ff, j_ff); end
      endcase

      if (csr_wr_en) begin
         case (csr_index)
            mme_pkg::REG_OP_MODE: op_mode_in = csr_wr_data[2:0];
            mme_pkg::REG_A_ROWS:  a_rows_in  = csr_wr_data[3:0];
            mme_pkg::REG_A_COLS:  a_cols_in  = csr_wr_data[3:0];
            mme_pkg::REG_B_ROWS:  b_rows_in  = csr_wr_data[3:0];
            mme_pkg::REG_B_COLS:  b_cols_in  = csr_wr_data[3:0];
            mme_pkg::REG_SCALAR:  scalar_in  = csr_wr_data;
            default: ;
         endcase
      end

      case (state_ff)
         mme_pkg::ST_IDLE: begin
            if (req_acc) begin
               a_we = (req_cmd == mme_pkg::CMD_WRITE_A) && in_range;
               b_we = (req_cmd == mme_pkg::CMD_WRITE_B) && in_range;
               if (req_cmd == mme_pkg::CMD_START && op_mode_ff <= mme_pkg::OP_SMUL) begin
                  mode_in = op_mode_ff;
                  rr_in = ear; rc_in = eac; n_in = 4'd1;
                  case (op_mode_ff)
                     mme_pkg::OP_AB:  begin rc_in = ebc; n_in = eac; end
                     mme_pkg::OP_ATB: begin rr_in = eac; rc_in = ebc; n_in = ear; end
                     mme_pkg::OP_ABT: begin rc_in = ebr; n_in = eac; end
                     default: ;
                  endcase
                  if ((op_mode_ff == mme_pkg::OP_AB && eac != ebr) ||
                      (op_mode_ff == mme_pkg::OP_ATB && ear != ebr) ||
                      (op_mode_ff == mme_pkg::OP_ABT && eac != ebc) ||
                      ((op_mode_ff == mme_pkg::OP_ADD || op_mode_ff == mme_pkg::OP_SUB) &&
                       (ear != ebr || eac != ebc))) begin
                     rsp_valid_in  = 1'b1;
                     rsp_row_in    = 3'd0;
                     rsp_col_in    = 3'd0;
                     rsp_value_in  = 32'sd0;
                     rsp_last_in   = 1'b1;
                     rsp_status_in = mme_pkg::STATUS_SHAPE;
                  end else begin
                     i_in = 4'd0; j_in = 4'd0; k_in = 4'd0;
                     acc_in = '0;
                     state_in = mme_pkg::ST_MAC;
                  end
               end
            end
         end
         mme_pkg::ST_MAC: begin
            issue = k_ff < n_ff;
            if (issue) k_in = k_ff + 4'd1;
            v1_in = issue;
            v2_in = v1_ff;
            if (v1_ff) begin
               prod_in = $signed(a_rdata) * mul_b;
               a_d_in  = $signed(a_rdata);
               b_d_in  = (mode_ff == mme_pkg::OP_SADD) ? scalar_ff : $signed(b_rdata);
            end
            if (v2_ff) acc_in = acc_ff + ACC_W'(prod_ff);
            if (!issue && !v1_ff && !v2_ff) state_in = mme_pkg::ST_EMIT;
         end
         mme_pkg::ST_EMIT: begin
            if (room) begin
               rsp_valid_in  = 1'b1;
               rsp_row_in    = i_ff[2:0];
               rsp_col_in    = j_ff[2:0];
               rsp_value_in  = result;
               rsp_last_in   = last_elem;
               rsp_status_in = mme_pkg::STATUS_OK;
               r_we = 1'b1;
               k_in = 4'd0;
               acc_in = '0;
               if (last_elem) begin
                  cr_in = 4'd0; cc_in = 4'd0;
                  state_in = mme_pkg::ST_COPY;
               end else begin
                  if (j_ff == rc_ff - 4'd1) begin
                     j_in = 4'd0; i_in = i_ff + 4'd1;
                  end else begin
                     j_in = j_ff + 4'd1;
                  end
                  state_in = mme_pkg::ST_MAC;
               end
            end
         end
         mme_pkg::ST_COPY: begin
            issue = cr_ff < rr_ff;
            cp_v_in = issue;
            cp_addr_in = r_raddr;
            if (issue) begin
               if (cc_ff == rc_ff - 4'd1) begin
                  cc_in = 4'd0; cr_in = cr_ff + 4'd1;
               end else begin
                  cc_in = cc_ff + 4'd1;
               end
            end
            if (cp_v_ff) begin
               a_we = 1'b1; a_waddr = cp_addr_ff; a_wdata = r_rdata;
            end
            if (!issue && !cp_v_ff) state_in = mme_pkg::ST_HOLD;
         end
         mme_pkg::ST_HOLD: begin
            a_rows_in = rr_ff;
            a_cols_in = rc_ff;
            state_in = mme_pkg::ST_IDLE;
         end
         default: state_in = mme_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mme_pkg::ST_IDLE;
         op_mode_ff   <= mme_pkg::OP_AB;
         a_rows_ff    <= 4'(MAX_DIM);
         a_cols_ff    <= 4'(MAX_DIM);
         b_rows_ff    <= 4'(MAX_DIM);
         b_cols_ff    <= 4'(MAX_DIM);
         scalar_ff    <= 32'sd0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         cp_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_mode_ff   <= op_mode_in;
         a_rows_ff    <= a_rows_in;
         a_cols_ff    <= a_cols_in;
         b_rows_ff    <= b_rows_in;
         b_cols_ff    <= b_cols_in;
         scalar_ff    <= scalar_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         cp_v_ff      <= cp_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff <= mode_in; rr_ff <= rr_in; rc_ff <= rc_in; n_ff <= n_in;
      i_ff <= i_in; j_ff <= j_in; k_ff <= k_in;
      prod_ff <= prod_in; acc_ff <= acc_in; a_d_ff <= a_d_in; b_d_ff <= b_d_in;
      cr_ff <= cr_in; cc_ff <= cc_in; cp_addr_ff <= cp_addr_in;
      rsp_row_ff <= rsp_row_in; rsp_col_ff <= rsp_col_in; rsp_value_ff <= rsp_value_in;
      rsp_last_ff <= rsp_last_in; rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_last_flag = rsp_last_ff;
   assign rsp_status    = rsp_status_ff;

`ifndef SYNTHESIS
   a_mac_pipe: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> $past(v1_ff)) else $error("product stage without read stage");
   a_emit_beat: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mme_pkg::ST_EMIT && room) |=> rsp_valid_ff)
      else $error("emitted element lost");
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> rsp_last_flag)
      else $error("error beat not marked last");
   a_copy_quiet: assert property (@(posedge clock) disable iff (reset)
      cp_v_ff |-> (state_ff == mme_pkg::ST_COPY && req_stall))
      else $error("copy write outside copy pass");
`endif
endmodule
